// File: hdl/qoi_pkg.sv
// ============================================================================
// qoi_pkg: shared types and constants for the quaternion integrator
// Fixed-point limits, rounding offsets, register map, product term tables and pipeline stage records.
// ============================================================================
package qoi_pkg;

    // Saturation limits
    localparam logic signed [49:0] H_MAX   = 50'sd4294967295;
    localparam logic signed [36:0] SUM_MAX = 37'sd2147483647;
    localparam logic signed [33:0] Q_MAX   = 34'sd2147483647;
    localparam logic signed [33:0] Q_MIN   = -34'sd2147483648;

    // Rounding offsets
    localparam logic signed [49:0] H_HALF = 50'sd4;
    localparam logic signed [64:0] P_HALF = 65'sd536870912;

    // Register map
    localparam logic       IDX_TIME_STEP   = 1'b0;
    localparam logic [16:0] TIME_STEP_RESET = 17'd1092;

    // Iteration counts of the square root and divider pipelines
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    // Hamilton product terms: which h component times which q component.
    // h: 0 = i, 1 = j, 2 = k; q: 0 = i, 1 = j, 2 = k, 3 = r
    localparam logic [1:0] PH [12] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd0,
                                       2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] PQ [12] = '{2'd3, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2,
                                       2'd3, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2};

    // One square root stage
    typedef struct packed {
        logic [63:0]      rem;
        logic [63:0]      res;
        logic [3:0][31:0] t;
        logic             deg;
    } t_sq_stage;

    // One divider stage, four lanes sharing the divisor
    typedef struct packed {
        logic [3:0][33:0] rem;
        logic [3:0][31:0] low;
        logic [3:0][31:0] q;
        logic [3:0]       neg;
        logic [33:0]      d;
        logic             deg;
    } t_div_stage;

endpackage

// File: hdl/quaternion_orientation_integrator.sv
// ============================================================================
// quaternion_orientation_integrator: first-order quaternion update
// Adds h*q (h = omega*dt/2) to q and normalizes the sum, fully pipelined.
// ============================================================================
//
//  channel   handshake          payload
//  --------  -----------------  -------------------------------------------
//  input     i_valid / o_stall  i_spin_pitch/yaw/roll, i_orient_i/j/k/r
//  output    o_valid / i_stall  o_new_i/j/k/r, o_degenerate
//  config    APB write/read     time_step at byte address 0
//
//  One transaction enters per cycle while the output is not stalled; the
//  pipeline holds a 32-stage square root and a 32-stage restoring divider.
//  A stall while the output holds a valid result freezes the whole pipeline; o_stall follows it.
//  Reset clears all valid bits and loads time_step with 1092.
//
module quaternion_orientation_integrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_spin_pitch,
    input  logic signed [31:0] i_spin_yaw,
    input  logic signed [31:0] i_spin_roll,
    input  logic signed [31:0] i_orient_i,
    input  logic signed [31:0] i_orient_j,
    input  logic signed [31:0] i_orient_k,
    input  logic signed [31:0] i_orient_r,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_i,
    output logic signed [31:0] o_new_j,
    output logic signed [31:0] o_new_k,
    output logic signed [31:0] o_new_r,
    output logic               o_degenerate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import qoi_pkg::*;

    localparam int LAT = 75;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [16:0] r_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= TIME_STEP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == IDX_TIME_STEP) begin
            r_ts <= pwdata[16:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == IDX_TIME_STEP) ? {15'd0, r_ts} : 32'd0;

    // ------------------------------------------------------------------
    // Pipeline control: one shared enable
    // ------------------------------------------------------------------
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = r_vld[LAT-1] && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] sat_sum(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > SUM_MAX) begin
            r = 32'sd2147483647;
        end else if (v < -SUM_MAX) begin
            r = -32'sd2147483647;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_sq_stage sq_step(input t_sq_stage s, input int k);
        t_sq_stage   r;
        logic [63:0] bitv;
        logic [63:0] trial;
        r     = s;
        bitv  = 64'd1 << (62 - 2 * k);
        trial = s.res + bitv;
        if (s.rem >= trial) begin
            r.rem = s.rem - trial;
            r.res = (s.res >> 1) + bitv;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage  r;
        logic [34:0] trial;
        logic        ge;
        r = s;
        for (int l = 0; l < 4; l++) begin
            trial = {s.rem[l], s.low[l][31]};
            ge    = trial >= {1'b0, s.d};
            r.rem[l] = ge ? 34'(trial - {1'b0, s.d}) : trial[33:0];
            r.low[l] = {s.low[l][30:0], 1'b0};
            r.q[l]   = {s.q[l][30:0], ge};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stages 1-2: h = omega * dt / 2, rounded and saturated
    // ------------------------------------------------------------------
    logic signed [49:0] r_hp [3];
    logic signed [31:0] r_q1 [4];
    logic signed [32:0] r_h  [3];
    logic signed [31:0] r_q2 [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hp[0] <= i_spin_pitch * $signed({1'b0, r_ts});
            r_hp[1] <= i_spin_yaw   * $signed({1'b0, r_ts});
            r_hp[2] <= i_spin_roll  * $signed({1'b0, r_ts});
            r_q1[0] <= i_orient_i;
            r_q1[1] <= i_orient_j;
            r_q1[2] <= i_orient_k;
            r_q1[3] <= i_orient_r;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [49:0] v;
        if (w_en) begin
            for (int n = 0; n < 3; n++) begin
                v = (r_hp[n] + H_HALF) >>> 3;
                if (v > H_MAX) begin
                    r_h[n] <= 33'sd4294967295;
                end else if (v < -H_MAX) begin
                    r_h[n] <= -33'sd4294967295;
                end else begin
                    r_h[n] <= v[32:0];
                end
            end
            r_q2 <= r_q1;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3-4: twelve product terms, each rounded to Q.30
    // ------------------------------------------------------------------
    logic signed [64:0] r_p  [12];
    logic signed [31:0] r_q3 [4];
    logic signed [34:0] r_m  [12];
    logic signed [31:0] r_q4 [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int n = 0; n < 12; n++) begin
                r_p[n] <= r_h[PH[n]] * r_q2[PQ[n]];
            end
            r_q3 <= r_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [64:0] v;
        if (w_en) begin
            for (int n = 0; n < 12; n++) begin
                v      = (r_p[n] + P_HALF) >>> 30;
                r_m[n] <= v[34:0];
            end
            r_q4 <= r_q3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add the step to q and saturate
    // ------------------------------------------------------------------
    logic signed [31:0] r_t [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t[0] <= sat_sum(37'(r_q4[0]) + 37'(r_m[0]) + 37'(r_m[1]) - 37'(r_m[2]));
            r_t[1] <= sat_sum(37'(r_q4[1]) + 37'(r_m[3]) + 37'(r_m[4]) - 37'(r_m[5]));
            r_t[2] <= sat_sum(37'(r_q4[2]) + 37'(r_m[6]) + 37'(r_m[7]) - 37'(r_m[8]));
            r_t[3] <= sat_sum(37'(r_q4[3])
                              - (37'(r_m[9]) + 37'(r_m[10]) + 37'(r_m[11])));
        end
    end

    // ------------------------------------------------------------------
    // Stages 6-8: squared length
    // ------------------------------------------------------------------
    logic [61:0]        r_sqr [4];
    logic signed [31:0] r_t6  [4];
    logic [62:0]        r_pr  [2];
    logic signed [31:0] r_t7  [4];
    t_sq_stage          r_sq  [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        logic signed [63:0] v;
        if (w_en) begin
            for (int n = 0; n < 4; n++) begin
                v        = r_t[n] * r_t[n];
                r_sqr[n] <= v[61:0];
            end
            r_t6 <= r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pr[0] <= 63'(r_sqr[0]) + 63'(r_sqr[1]);
            r_pr[1] <= 63'(r_sqr[2]) + 63'(r_sqr[3]);
            r_t7    <= r_t6;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] len2;
        if (w_en) begin
            len2          = 64'(r_pr[0]) + 64'(r_pr[1]);
            r_sq[0].rem   <= len2;
            r_sq[0].res   <= '0;
            r_sq[0].deg   <= (len2 == 64'd0);
            for (int n = 0; n < 4; n++) begin
                r_sq[0].t[n] <= r_t7[n];
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sq[k+1] <= sq_step(r_sq[k], k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Round the root to nearest
    // ------------------------------------------------------------------
    logic [32:0]      r_s;
    logic [3:0][31:0] r_rt;
    logic             r_rdeg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s    <= {1'b0, r_sq[SQRT_STEPS].res[31:0]}
                      + 33'(r_sq[SQRT_STEPS].rem > r_sq[SQRT_STEPS].res);
            r_rt   <= r_sq[SQRT_STEPS].t;
            r_rdeg <= r_sq[SQRT_STEPS].deg;
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: numerator 2*t*2^30 + s over 2*s, sign and magnitude
    // ------------------------------------------------------------------
    t_div_stage r_dv [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        logic signed [63:0] nv;
        logic [63:0]        mag;
        if (w_en) begin
            for (int l = 0; l < 4; l++) begin
                nv  = $signed({r_rt[l][31], r_rt[l], 31'd0}) + $signed({31'd0, r_s});
                mag = nv[63] ? 64'(-nv) : 64'(nv);
                r_dv[0].neg[l] <= nv[63];
                r_dv[0].rem[l] <= {3'd0, mag[62:32]};
                r_dv[0].low[l] <= mag[31:0];
                r_dv[0].q[l]   <= '0;
            end
            r_dv[0].d   <= {r_s, 1'b0};
            r_dv[0].deg <= r_rdeg;
        end
    end

    // ------------------------------------------------------------------
    // Restoring division: one quotient bit per stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv[k+1] <= div_step(r_dv[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: apply floor for negatives, clamp, zero a degenerate result
    // ------------------------------------------------------------------
    logic signed [31:0] r_new [4];
    logic               r_deg;

    always_ff @(posedge i_clk) begin
        logic signed [33:0] qs;
        logic               nz;
        if (w_en) begin
            for (int l = 0; l < 4; l++) begin
                nz = (r_dv[DIV_STEPS].rem[l] != 34'd0);
                qs = $signed({2'b00, r_dv[DIV_STEPS].q[l]});
                if (r_dv[DIV_STEPS].neg[l]) begin
                    qs = -(qs + $signed({33'd0, nz}));
                end
                if (r_dv[DIV_STEPS].deg) begin
                    r_new[l] <= '0;
                end else if (qs > Q_MAX) begin
                    r_new[l] <= 32'sd2147483647;
                end else if (qs < Q_MIN) begin
                    r_new[l] <= -32'sd2147483648;
                end else begin
                    r_new[l] <= qs[31:0];
                end
            end
            r_deg <= r_dv[DIV_STEPS].deg;
        end
    end

    assign o_new_i      = r_new[0];
    assign o_new_j      = r_new[1];
    assign o_new_k      = r_new[2];
    assign o_new_r      = r_new[3];
    assign o_degenerate = r_deg;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_new_i == 0 && o_new_j == 0 && o_new_k == 0 && o_new_r == 0))
        else $error("degenerate result not zero");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_degenerate) |->
        (o_new_i <= 32'sd1073741824 && o_new_i >= -32'sd1073741824 &&
         o_new_j <= 32'sd1073741824 && o_new_j >= -32'sd1073741824 &&
         o_new_k <= 32'sd1073741824 && o_new_k >= -32'sd1073741824 &&
         o_new_r <= 32'sd1073741824 && o_new_r >= -32'sd1073741824))
        else $error("normalized component exceeds one");
`endif

endmodule

// File: sim/qoi_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// qoi_checker: result predictor and scoreboard for the quaternion integrator
// Watches the config port and both channels. Each accepted input transaction
// gets its expected normalized quaternion computed and queued. Each accepted
// output transaction is compared field by field against the oldest entry.
// ============================================================================
module qoi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_spin_pitch,
    input  logic signed [31:0] i_spin_yaw,
    input  logic signed [31:0] i_spin_roll,
    input  logic signed [31:0] i_orient_i,
    input  logic signed [31:0] i_orient_j,
    input  logic signed [31:0] i_orient_k,
    input  logic signed [31:0] i_orient_r,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_new_i,
    input  logic signed [31:0] i_new_j,
    input  logic signed [31:0] i_new_k,
    input  logic signed [31:0] i_new_r,
    input  logic               i_degenerate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_degenerate_seen
);
    import qoi_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic signed [31:0] qi;
        logic signed [31:0] qj;
        logic signed [31:0] qk;
        logic signed [31:0] qr;
        logic               deg;
    } t_orient;

    localparam t_wide H_LIM   = 128'sd4294967295;
    localparam t_wide SUM_LIM = 128'sd2147483647;

    logic [16:0] time_step_copy;
    t_orient     expected_q[$];

    // Floor division, divisor positive
    function automatic t_wide fdiv(input t_wide a, input t_wide b);
        t_wide q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_wide clamp(input t_wide v, input t_wide lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Q.30 h term times Q2.30 component, rounded half up
    function automatic t_wide mul_q30(input t_wide h, input t_wide q);
        return fdiv(h * q + (128'sd1 <<< 29), 128'sd1 <<< 30);
    endfunction

    // Square root rounded to nearest
    function automatic t_wide sqrt_nearest(input t_wide x);
        logic [127:0] rem, res, bit_v;
        rem   = x;
        res   = 0;
        bit_v = 128'd1 << 62;
        while (bit_v > rem) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        if (x - res * res > res) res = res + 1;
        return t_wide'(res);
    endfunction

    function automatic t_orient integrate_step(
        input logic signed [31:0] sp, sy, sr, qi, qj, qk, qr,
        input logic [16:0] dt
    );
        t_wide   dtw, hi, hj, hk, ti, tj, tk, tr, len2, s, q;
        t_wide   t[4];
        t_orient o;
        dtw = dt;
        hi = clamp(fdiv(t_wide'(sp) * dtw + 4, 8), H_LIM);
        hj = clamp(fdiv(t_wide'(sy) * dtw + 4, 8), H_LIM);
        hk = clamp(fdiv(t_wide'(sr) * dtw + 4, 8), H_LIM);
        ti = qi;
        tj = qj;
        tk = qk;
        tr = qr;
        t[0] = clamp(ti + mul_q30(hi, tr) + mul_q30(hj, tk) - mul_q30(hk, tj), SUM_LIM);
        t[1] = clamp(tj + mul_q30(hj, tr) + mul_q30(hk, ti) - mul_q30(hi, tk), SUM_LIM);
        t[2] = clamp(tk + mul_q30(hk, tr) + mul_q30(hi, tj) - mul_q30(hj, ti), SUM_LIM);
        t[3] = clamp(tr - (mul_q30(hi, ti) + mul_q30(hj, tj) + mul_q30(hk, tk)),
                     SUM_LIM);
        len2 = t[0] * t[0] + t[1] * t[1] + t[2] * t[2] + t[3] * t[3];
        o = '{0, 0, 0, 0, 1'b1};
        if (len2 == 0) return o;
        s = sqrt_nearest(len2);
        o.deg = 1'b0;
        for (int n = 0; n < 4; n++) begin
            q = fdiv(2 * (t[n] <<< 30) + s, 2 * s);
            if (q > SUM_LIM) q = SUM_LIM;
            if (q < -SUM_LIM - 1) q = -SUM_LIM - 1;
            unique case (n)
                0: o.qi = q[31:0];
                1: o.qj = q[31:0];
                2: o.qk = q[31:0];
                default: o.qr = q[31:0];
            endcase
        end
        return o;
    endfunction

    // Track the time step, predict on input, compare on output
    always @(posedge i_clk) begin
        t_orient want;
        if (!i_rst_n) begin
            time_step_copy = TIME_STEP_RESET;
            expected_q.delete();
            o_errors          = 0;
            o_checked         = 0;
            o_degenerate_seen = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == IDX_TIME_STEP)
                time_step_copy = pwdata[16:0];
            if (i_valid && !i_in_stall)
                expected_q.push_back(integrate_step(i_spin_pitch, i_spin_yaw,
                    i_spin_roll, i_orient_i, i_orient_j, i_orient_k, i_orient_r,
                    time_step_copy));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result i=%h j=%h k=%h r=%h deg=%b",
                             $time, i_new_i, i_new_j, i_new_k, i_new_r, i_degenerate);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    o_checked++;
                    if (i_degenerate) o_degenerate_seen++;
                    if (want.qi !== i_new_i || want.qj !== i_new_j ||
                        want.qk !== i_new_k || want.qr !== i_new_r ||
                        want.deg !== i_degenerate) begin
                        $display("%0t: expected i=%h j=%h k=%h r=%h deg=%b", $time,
                                 want.qi, want.qj, want.qk, want.qr, want.deg);
                        $display("%0t: actual   i=%h j=%h k=%h r=%h deg=%b", $time,
                                 i_new_i, i_new_j, i_new_k, i_new_r, i_degenerate);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for the quaternion integrator
// Steps through several time step settings, sends directed corner cases and
// random bodies with random gaps and output stalls, and reports the result.
// ============================================================================
module testbench;
    import qoi_pkg::*;

    localparam int  LATENCY      = 75;
    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  PER_PHASE    = 160;
    localparam int  HOLD_CYCLES  = 400;
    localparam logic IDX_UNUSED  = 1'b1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] spin_p = 0, spin_y = 0, spin_r = 0;
    logic signed [31:0] q_i = 0, q_j = 0, q_k = 0, q_r = 0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [31:0] o_new_i, o_new_j, o_new_k, o_new_r;
    logic               o_degenerate;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int  errors, pending, checked, degen_seen;
    int  cycles = 0;
    int  sent = 0;
    bit  hold_done = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    quaternion_orientation_integrator i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_spin_pitch(spin_p), .i_spin_yaw(spin_y), .i_spin_roll(spin_r),
        .i_orient_i(q_i), .i_orient_j(q_j), .i_orient_k(q_k), .i_orient_r(q_r),
        .o_valid, .i_stall, .o_new_i, .o_new_j, .o_new_k, .o_new_r, .o_degenerate,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    qoi_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall),
        .i_spin_pitch(spin_p), .i_spin_yaw(spin_y), .i_spin_roll(spin_r),
        .i_orient_i(q_i), .i_orient_j(q_j), .i_orient_k(q_k), .i_orient_r(q_r),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_new_i(o_new_i), .i_new_j(o_new_j), .i_new_k(o_new_k), .i_new_r(o_new_r),
        .i_degenerate(o_degenerate),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_degenerate_seen(degen_seen)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("quaternion_orientation_integrator: mismatch");
            $finish;
        end
    end

    // Write one register: setup cycle then access cycle
    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Offer one body and hold it until accepted
    task automatic send_body(input logic signed [31:0] p, y, r, a, b, c, d,
                             input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        spin_p = p; spin_y = y; spin_r = r;
        q_i = a; q_j = b; q_k = c; q_r = d;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] near_unit();
        return $signed($urandom) >>> 1;
    endfunction

    // Random body: mostly plausible orientations and spins, some raw noise
    task automatic send_random(input bit no_gaps);
        int kind;
        int gap;
        int sh;
        gap  = no_gaps ? 0 : $urandom_range(0, 7);
        kind = $urandom_range(0, 9);
        sh   = $urandom_range(0, 16);
        if (kind < 6)
            send_body($signed($urandom) >>> sh, $signed($urandom) >>> sh,
                      $signed($urandom) >>> sh, near_unit(), near_unit(),
                      near_unit(), near_unit(), gap);
        else if (kind < 9)
            send_body($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, gap);
        else
            send_body($signed($urandom) >>> 28, 0, $signed($urandom) >>> 28,
                      $signed($urandom) >>> 29, $signed($urandom) >>> 29,
                      0, $signed($urandom) >>> 29, gap);
    endtask

    // Output side: random stall per transaction, one long hold-off
    initial begin
        int gap;
        bit calm;
        int taken;
        taken = 0;
        calm  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (!hold_done && sent >= 300) begin
                hold_done = 1'b1;
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (gap > 0) begin
                i_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    // Stimulus: directed corners, then random bodies per time step setting
    initial begin
        logic [31:0] steps[7];
        bit no_gaps;
        steps = '{32'd1092, 32'd65536, 32'd1, 32'd0, 32'h1FFFF, 32'd3000, 32'd65};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity, zero length, rails, huge spin, mixed signs
        send_body(0, 0, 0, 0, 0, 0, 32'sh40000000, 0);
        send_body(0, 0, 0, 0, 0, 0, 0, 0);
        send_body(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        send_body(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_body(32'sh80000000, 32'sh7FFFFFFF, 0,
                  32'sh20000000, 32'sh20000000, 32'sh20000000, 32'sh20000000, 1);
        send_body(32'h00010000, 0, 0, 0, 0, 0, 32'sh40000000, 0);
        send_body(0, 32'h00010000, 0, 0, 32'sh40000000, 0, 0, 2);
        send_body(0, 0, 32'hFFFF0000, 0, 0, 32'sh40000000, 0, 0);
        send_body(0, 0, 0, 32'sh00000001, 0, 0, 0, 0);
        send_body(0, 0, 0, 32'shFFFFFFFF, 32'shFFFFFFFF, 0, 0, 0);
        send_body(32'h00100000, 32'hFFF00000, 32'h00080000,
                  32'shC0000000, 32'sh40000000, 0, 0, 3);
        send_body($urandom, $urandom, $urandom, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                wait_idle();
                reg_write(IDX_TIME_STEP, steps[ph]);
                reg_write(IDX_UNUSED, $urandom);
            end
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < PER_PHASE; n++) begin
                if (ph == 2 && n == PER_PHASE / 2) wait_idle();
                send_random(no_gaps && n < PER_PHASE / 2);
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("sent %0d bodies over 7 time step settings, %0d results checked",
                 sent, checked);
        $display("%0d degenerate results, %0d mismatches", degen_seen, errors);
        if (errors == 0)
            $display("quaternion_orientation_integrator: match");
        else
            $display("quaternion_orientation_integrator: mismatch");
        $finish;
    end

endmodule
